>>> src/png_unf_pkg.sv
// ============================================================================
// png_unf_pkg: shared types, codes and helpers of the scanline unfilter
// row filter codes, register indexes, byte helpers and a mod-3 reduction
// ============================================================================
package png_unf_pkg;

    // row filter codes as carried by the filter byte
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // configuration register map
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA   = 4'd1;

    localparam int POS_W = 14;
    localparam logic [7:0]  MIN_ALPHA   = 8'd8;
    localparam logic [7:0]  OPAQUE      = 8'd255;
    localparam logic [23:0] BLACK_SUBST = 24'h000001;

    // one byte of context for the reconstruction datapath
    typedef struct packed {
        filt_t      filt;
        logic [7:0] raw;
        logic [7:0] left;
        logic [7:0] up;
        logic [7:0] upleft;
    } recon_in_t;

    function automatic logic [7:0] get_byte(input logic [31:0] w, input logic [1:0] k);
        return w[8*k +: 8];
    endfunction

    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] k,
                                             input logic [7:0] v);
        logic [31:0] r;
        r = w;
        r[8*k +: 8] = v;
        return r;
    endfunction

    // 4 = 1 mod 3, so the base-4 digit sum keeps the residue
    function automatic logic [1:0] mod3(input logic [POS_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6])
          + 5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        u = 3'(t[1:0]) + 3'(t[2]);
        if (u >= 3'd3) begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

endpackage

>>> src/png_unf_row_mem.sv
// ============================================================================
// png_unf_row_mem: prior-row byte store
// one write port, one read port with registered data and write-first bypass
// ============================================================================
module png_unf_row_mem #(
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/png_unf_recon.sv
// ============================================================================
// png_unf_recon: byte reconstruction
// undoes none, sub, up, average and paeth filtering for one sample byte
// ============================================================================
module png_unf_recon (
    input  png_unf_pkg::recon_in_t ctx,
    output logic [7:0]             recon_byte
);

    logic signed [10:0] sa, sb, sc, pv;
    logic signed [10:0] da, db, dc;
    logic [10:0]        pa, pb, pc;
    logic [7:0]         paeth_pred;
    logic [8:0]         avg_sum;
    logic [7:0]         pred;

    // paeth predictor
    always_comb begin
        sa = signed'({3'b000, ctx.left});
        sb = signed'({3'b000, ctx.up});
        sc = signed'({3'b000, ctx.upleft});
        pv = sa + sb - sc;
        da = pv - sa;
        db = pv - sb;
        dc = pv - sc;
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            paeth_pred = ctx.left;
        end else if (pb <= pc) begin
            paeth_pred = ctx.up;
        end else begin
            paeth_pred = ctx.upleft;
        end
    end

    assign avg_sum = 9'(ctx.left) + 9'(ctx.up);

    always_comb begin
        unique case (ctx.filt)
            png_unf_pkg::FILT_SUB:   pred = ctx.left;
            png_unf_pkg::FILT_UP:    pred = ctx.up;
            png_unf_pkg::FILT_AVG:   pred = avg_sum[8:1];
            png_unf_pkg::FILT_PAETH: pred = paeth_pred;
            default:                 pred = 8'd0;
        endcase
    end

    assign recon_byte = ctx.raw + pred;

endmodule

>>> src/png_scanline_unfilter_to_rgb.sv
// a taken byte waits in the input register until it fires; its word is registered to m_valid
// throughput: one byte per cycle while no output word waits; the prior-row read is prefetched
// from the next row position, so back-to-back bytes never wait on the row store
// reset: synchronous, active low; position, filter state and handshakes clear, the
// registers return to width 1 and rgba; the row store is not cleared (first row reads zero)
// ============================================================================
// png_scanline_unfilter_to_rgb: png scanline unfilter to packed rgb
// takes the inflated image byte stream, undoes the per-row filters against the
// left pixel and the previous row, and emits one 0xRRGGBB word per pixel
// ============================================================================
module png_scanline_unfilter_to_rgb #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [png_unf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [png_unf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // byte input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_raw_byte,
    input  logic                                s_image_start,
    // pixel output channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [23:0]                         m_pixel_color,
    output logic                                m_row_end,
    output logic                                m_bad_filter
);

    localparam int ROW_STORE = MAX_WIDTH * 4;
    localparam int ROW_AW    = $clog2(ROW_STORE);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);
    localparam int LEN_W     = $clog2(ROW_STORE + 1);
    localparam int POS_W     = png_unf_pkg::POS_W;

    // configuration registers
    logic [12:0] image_width_reg;
    logic        has_alpha_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_raw_reg;
    logic        in_start_reg;

    // row state
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [1:0]          pos_mod3_reg;
    png_unf_pkg::filt_t  filt_reg, filt_next;
    logic [31:0]         left_reg, left_next;
    logic [31:0]         upleft_reg, upleft_next;
    logic [31:0]         collect_reg, collect_next;
    logic                first_row_reg, first_row_next;
    logic                expect_filt_reg, expect_filt_next;
    logic                halted_reg, halted_next;

    // output register
    logic        m_valid_reg;
    logic [23:0] m_pixel_color_reg;
    logic        m_row_end_reg;
    logic        m_bad_filter_reg;

    // per-byte datapath
    logic                   fire;
    logic [1:0]             slot;
    logic                   last_slot;
    logic [31:0]            pos_ext;
    logic [31:0]            pos_next_ext;
    logic                   in_store;
    logic [7:0]             rd_byte;
    logic [7:0]             up_byte;
    png_unf_pkg::recon_in_t ctx;
    logic [7:0]             recon_byte;
    logic [31:0]            collect_new;
    logic [7:0]             alpha;
    logic [23:0]            rgb_swapped;
    logic [23:0]            pix_color;
    logic [POS_W:0]         pos_inc;
    logic [WID_W-1:0]       width_eff;
    logic [LEN_W-1:0]       row_len;
    logic                   row_end_hit;

    // result of this cycle's byte
    logic        res_load;
    logic [23:0] res_color;
    logic        res_end;
    logic        res_bad;
    logic        mem_we;

    // configuration port always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= 13'd1;
            has_alpha_reg   <= 1'b1;
        end else if (cfg_valid) begin
            if (cfg_index == png_unf_pkg::REG_IMAGE_WIDTH) begin
                image_width_reg <= cfg_wdata[12:0];
            end else if (cfg_index == png_unf_pkg::REG_HAS_ALPHA) begin
                has_alpha_reg <= cfg_wdata[0];
            end
        end
    end

    // the byte in the input register moves on when the result slot can take a word
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_raw_reg   <= s_raw_byte;
            in_start_reg <= s_image_start;
        end
    end

    // byte slot within the pixel, from the current pixel size
    assign slot      = has_alpha_reg ? pos_reg[1:0] : pos_mod3_reg;
    assign last_slot = has_alpha_reg ? (pos_reg[1:0] == 2'd3) : (pos_mod3_reg == 2'd2);

    // row store lookup; positions past the store read as zero
    assign pos_ext  = 32'(pos_reg);
    assign in_store = pos_ext < 32'(ROW_STORE);
    assign up_byte  = (!first_row_reg && in_store) ? rd_byte : 8'd0;

    assign ctx.filt   = filt_reg;
    assign ctx.raw    = in_raw_reg;
    assign ctx.left   = png_unf_pkg::get_byte(left_reg, slot);
    assign ctx.up     = up_byte;
    assign ctx.upleft = first_row_reg ? 8'd0 : png_unf_pkg::get_byte(upleft_reg, slot);

    png_unf_recon u_recon (
        .ctx        (ctx),
        .recon_byte (recon_byte)
    );

    // pixel assembly and color packing
    assign collect_new = png_unf_pkg::put_byte(collect_reg, slot, recon_byte);
    assign alpha       = has_alpha_reg ? collect_new[31:24] : png_unf_pkg::OPAQUE;
    assign rgb_swapped = {collect_new[7:0], collect_new[15:8], collect_new[23:16]};

    always_comb begin
        if (alpha < png_unf_pkg::MIN_ALPHA) begin
            pix_color = 24'd0;
        end else if (rgb_swapped == 24'd0) begin
            pix_color = png_unf_pkg::BLACK_SUBST;
        end else begin
            pix_color = rgb_swapped;
        end
    end

    // row length from the clamped width
    always_comb begin
        if (image_width_reg == 13'd0) begin
            width_eff = WID_W'(1);
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            width_eff = WID_W'(MAX_WIDTH);
        end else begin
            width_eff = WID_W'(image_width_reg);
        end
    end

    assign row_len = has_alpha_reg ? (LEN_W'(width_eff) << 2)
                                   : ((LEN_W'(width_eff) << 1) + LEN_W'(width_eff));
    assign pos_inc     = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign row_end_hit = 32'(pos_inc) >= 32'(row_len);

    // state update for the byte that fires
    always_comb begin
        logic halted_eff;
        logic expect_eff;

        pos_next         = pos_reg;
        filt_next        = filt_reg;
        left_next        = left_reg;
        upleft_next      = upleft_reg;
        collect_next     = collect_reg;
        first_row_next   = first_row_reg;
        expect_filt_next = expect_filt_reg;
        halted_next      = halted_reg;
        res_load         = 1'b0;
        res_color        = 24'd0;
        res_end          = 1'b0;
        res_bad          = 1'b0;
        mem_we           = 1'b0;
        halted_eff       = halted_reg;
        expect_eff       = expect_filt_reg;

        if (fire) begin
            // image start restarts position, first row and error state
            if (in_start_reg) begin
                pos_next         = '0;
                left_next        = '0;
                upleft_next      = '0;
                collect_next     = '0;
                first_row_next   = 1'b1;
                expect_filt_next = 1'b1;
                halted_next      = 1'b0;
                halted_eff       = 1'b0;
                expect_eff       = 1'b1;
            end

            if (!halted_eff) begin
                if (expect_eff) begin
                    if (in_raw_reg > 8'(png_unf_pkg::FILT_PAETH)) begin
                        // unknown filter: one error word, then drop bytes until image start
                        halted_next = 1'b1;
                        res_load    = 1'b1;
                        res_bad     = 1'b1;
                    end else begin
                        filt_next        = png_unf_pkg::filt_t'(in_raw_reg[2:0]);
                        expect_filt_next = 1'b0;
                        pos_next         = '0;
                        left_next        = '0;
                        upleft_next      = '0;
                        collect_next     = '0;
                    end
                end else begin
                    // sample byte
                    upleft_next  = png_unf_pkg::put_byte(upleft_reg, slot, up_byte);
                    mem_we       = in_store;
                    collect_next = collect_new;
                    pos_next     = pos_inc[POS_W-1:0];
                    if (last_slot) begin
                        res_load  = 1'b1;
                        res_color = pix_color;
                        res_end   = row_end_hit;
                        left_next = collect_new;
                        if (row_end_hit) begin
                            // next row opens with its filter byte
                            pos_next         = '0;
                            left_next        = '0;
                            upleft_next      = '0;
                            collect_next     = '0;
                            expect_filt_next = 1'b1;
                            first_row_next   = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            pos_mod3_reg    <= 2'd0;
            filt_reg        <= png_unf_pkg::FILT_NONE;
            left_reg        <= '0;
            upleft_reg      <= '0;
            collect_reg     <= '0;
            first_row_reg   <= 1'b1;
            expect_filt_reg <= 1'b1;
            halted_reg      <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            pos_mod3_reg    <= png_unf_pkg::mod3(pos_next);
            filt_reg        <= filt_next;
            left_reg        <= left_next;
            upleft_reg      <= upleft_next;
            collect_reg     <= collect_next;
            first_row_reg   <= first_row_next;
            expect_filt_reg <= expect_filt_next;
            halted_reg      <= halted_next;
        end
    end

    // the read address follows the next position so the data lines up with pos_reg
    assign pos_next_ext = 32'(pos_next);

    png_unf_row_mem #(
        .DEPTH (ROW_STORE)
    ) u_row_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (pos_ext[ROW_AW-1:0]),
        .wr_data (recon_byte),
        .rd_addr (pos_next_ext[ROW_AW-1:0]),
        .rd_data (rd_byte)
    );

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_pixel_color_reg <= res_color;
            m_row_end_reg     <= res_end;
            m_bad_filter_reg  <= res_bad;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_color = m_pixel_color_reg;
    assign m_row_end     = m_row_end_reg;
    assign m_bad_filter  = m_bad_filter_reg;

    // a halted stream produces no word unless the image restarts
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && halted_reg && !in_start_reg) |-> !res_load)
        else $error("word produced while halted on a bad filter");

    // an error word leaves the block halted
    a_bad_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_load && res_bad) |=> halted_reg)
        else $error("bad filter word without halt");

    // a row end returns to the filter byte at position zero
    a_row_end_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_load && res_end) |=> (expect_filt_reg && (pos_reg == '0)))
        else $error("row end did not rewind the row position");

    // tracked residue matches the position
    a_mod3_track: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_mod3_reg == png_unf_pkg::mod3(pos_reg))
        else $error("position residue out of step");

    // a word is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !res_load)
        else $error("pending output word overwritten");

endmodule
